### rtl/fbpa_pkg.sv
// Shared constants, codes and types for the fixed block pool allocator.
package fbpa_pkg;

  localparam int MAX_BLOCKS    = 1024;
  localparam int POINTER_BYTES = 4;

  localparam int INDEX_W  = $clog2(MAX_BLOCKS);
  localparam int COUNT_W  = $clog2(MAX_BLOCKS + 1);
  localparam int ADDR_W   = 32;
  localparam int SIZE_W   = 16;
  localparam int STATUS_W = 4;
  localparam int KIND_W   = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  typedef logic [KIND_W-1:0]   kind_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam kind_t KIND_GET    = 2'd0;
  localparam kind_t KIND_PUT    = 2'd1;
  localparam kind_t KIND_CREATE = 2'd2;

  localparam status_t ST_OK          = 4'd0;
  localparam status_t ST_BAD_ADDR    = 4'd1;
  localparam status_t ST_BAD_COUNT   = 4'd2;
  localparam status_t ST_BAD_SIZE    = 4'd3;
  localparam status_t ST_CREATED     = 4'd4;
  localparam status_t ST_NOT_CREATED = 4'd5;
  localparam status_t ST_EMPTY       = 4'd6;
  localparam status_t ST_NULL_BLOCK  = 4'd7;
  localparam status_t ST_FULL        = 4'd8;

  localparam cfg_idx_t CFG_POOL_BASE   = 2'd0;
  localparam cfg_idx_t CFG_POOL_BLOCKS = 2'd1;
  localparam cfg_idx_t CFG_BLOCK_BYTES = 2'd2;

  typedef struct packed {
    logic               en;
    logic [INDEX_W-1:0] addr;
    logic [INDEX_W-1:0] data;
  } link_wr_t;

  typedef struct packed {
    logic               en;
    logic [INDEX_W-1:0] addr;
  } link_rd_t;

endpackage

### rtl/fbpa_in_if.sv
// Request channel of the block pool allocator.
interface fbpa_in_if
  import fbpa_pkg::*;
  ();
  logic               valid;
  logic               ready;
  kind_t              kind;
  logic [INDEX_W-1:0] release_index;
  logic               release_present;

  modport source (output valid, kind, release_index, release_present, input ready);
  modport sink (input valid, kind, release_index, release_present, output ready);
endinterface

### rtl/fbpa_out_if.sv
// Result channel of the block pool allocator.
interface fbpa_out_if
  import fbpa_pkg::*;
  ();
  logic               valid;
  logic               ready;
  status_t            status;
  logic [INDEX_W-1:0] granted_index;
  logic [ADDR_W-1:0]  granted_address;
  logic [COUNT_W-1:0] blocks_free;

  modport source (output valid, status, granted_index, granted_address, blocks_free,
                  input ready);
  modport sink (input valid, status, granted_index, granted_address, blocks_free,
                output ready);
endinterface

### rtl/fbpa_link_ram.sv
// Link memory of the free list: one write port, one registered read port.
module fbpa_link_ram
  import fbpa_pkg::*;
(
  input  logic               clk,
  input  link_wr_t           wr,
  input  link_rd_t           rd,
  output logic [INDEX_W-1:0] rd_data
);

  logic [INDEX_W-1:0] mem [MAX_BLOCKS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

### rtl/fixed_block_pool_allocator_core.sv
// Top level of the fixed block pool allocator: control, registers and link memory.
// Put, kind 3 and every error answer in the cycle after the transfer; a get answers
// from the S_GET state, after the link memory read that gives the next head.
// A successful create sweeps the link memory one entry a cycle, entries 0 to pool_blocks - 1.
// A new request is taken in the cycle its predecessor's result is delivered.
// Reset clears the control state and the pool; the link memory is not cleared.
module fixed_block_pool_allocator_core
  import fbpa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  cfg_idx_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  fbpa_in_if.sink               in_item,
  fbpa_out_if.source            out_item
);

  localparam int PROD_W = INDEX_W + SIZE_W;

  typedef enum logic [1:0] {S_IDLE, S_GET, S_FILL} state_t;

  state_t state;

  logic [ADDR_W-1:0]  pool_base;
  logic [COUNT_W-1:0] pool_blocks;
  logic [SIZE_W-1:0]  block_bytes;

  logic [INDEX_W-1:0] free_head;
  logic [COUNT_W-1:0] free_total;
  logic [COUNT_W-1:0] capacity_total;
  logic               pool_made;
  logic [ADDR_W-1:0]  made_base;
  logic [SIZE_W-1:0]  made_size;

  logic [INDEX_W-1:0] fill_idx;
  logic [INDEX_W-1:0] fill_last;
  logic [PROD_W-1:0]  prod;

  logic               out_valid;
  status_t            out_status;
  logic [INDEX_W-1:0] out_index;
  logic [ADDR_W-1:0]  out_addr;
  logic [COUNT_W-1:0] out_free;

  link_wr_t           link_wr;
  link_rd_t           link_rd;
  logic [INDEX_W-1:0] link_rd_data;

  logic    in_fire;
  logic    get_ok;
  logic    put_ok;
  logic    fill_done;
  status_t create_status;
  status_t early_status;

  assign in_item.ready = (state == S_IDLE) && (!out_valid || out_item.ready);
  assign in_fire = in_item.valid && in_item.ready;

  assign out_item.valid           = out_valid;
  assign out_item.status          = out_status;
  assign out_item.granted_index   = out_index;
  assign out_item.granted_address = out_addr;
  assign out_item.blocks_free     = out_free;

  always_comb begin
    if (pool_base == '0) begin
      create_status = ST_BAD_ADDR;
    end else if (pool_blocks < COUNT_W'(2) || pool_blocks > COUNT_W'(MAX_BLOCKS)) begin
      create_status = ST_BAD_COUNT;
    end else if (block_bytes < SIZE_W'(POINTER_BYTES)) begin
      create_status = ST_BAD_SIZE;
    end else if ((pool_base % ADDR_W'(POINTER_BYTES)) != '0) begin
      create_status = ST_BAD_ADDR;
    end else if ((block_bytes % SIZE_W'(POINTER_BYTES)) != '0) begin
      create_status = ST_BAD_SIZE;
    end else if (pool_made) begin
      create_status = ST_CREATED;
    end else begin
      create_status = ST_OK;
    end
  end

  // Status of a request that is decided in its own transfer cycle.
  always_comb begin
    early_status = ST_OK;
    get_ok = 1'b0;
    put_ok = 1'b0;
    case (in_item.kind)
      KIND_GET: begin
        if (!pool_made) begin
          early_status = ST_NOT_CREATED;
        end else if (free_total == '0) begin
          early_status = ST_EMPTY;
        end else begin
          get_ok = 1'b1;
        end
      end
      KIND_PUT: begin
        if (!in_item.release_present) begin
          early_status = ST_NULL_BLOCK;
        end else if (!pool_made) begin
          early_status = ST_NOT_CREATED;
        end else if (free_total >= capacity_total) begin
          early_status = ST_FULL;
        end else begin
          put_ok = 1'b1;
        end
      end
      KIND_CREATE: early_status = create_status;
      default: early_status = ST_OK;
    endcase
  end

  assign fill_done = (fill_idx == fill_last);

  always_comb begin
    link_wr = '0;
    if (state == S_FILL) begin
      link_wr.en   = 1'b1;
      link_wr.addr = fill_idx;
      link_wr.data = fill_done ? '0 : fill_idx + INDEX_W'(1);
    end else if (in_fire && put_ok) begin
      link_wr.en   = 1'b1;
      link_wr.addr = in_item.release_index;
      link_wr.data = free_head;
    end
    link_rd.en   = in_fire && get_ok;
    link_rd.addr = free_head;
  end

  fbpa_link_ram u_link_ram (
    .clk     (clk),
    .wr      (link_wr),
    .rd      (link_rd),
    .rd_data (link_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base   <= '0;
      pool_blocks <= '0;
      block_bytes <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_POOL_BASE:   pool_base   <= cfg_data[ADDR_W-1:0];
        CFG_POOL_BLOCKS: pool_blocks <= cfg_data[COUNT_W-1:0];
        CFG_BLOCK_BYTES: block_bytes <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Payload of a pending get and of the fill sweep.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      prod      <= PROD_W'(free_head) * PROD_W'(made_size);
      fill_last <= INDEX_W'(pool_blocks - COUNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      free_head      <= '0;
      free_total     <= '0;
      capacity_total <= '0;
      pool_made      <= 1'b0;
      made_base      <= '0;
      made_size      <= '0;
      fill_idx       <= '0;
      out_status     <= ST_OK;
      out_index      <= '0;
      out_addr       <= '0;
      out_free       <= '0;
    end else begin
      if (out_valid && out_item.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            out_index <= '0;
            out_addr  <= '0;
            if (get_ok) begin
              out_index <= free_head;
              state     <= S_GET;
            end else if (in_item.kind == KIND_CREATE && create_status == ST_OK) begin
              fill_idx <= '0;
              state    <= S_FILL;
            end else begin
              out_valid  <= 1'b1;
              out_status <= early_status;
              if (put_ok) begin
                free_head  <= in_item.release_index;
                free_total <= free_total + COUNT_W'(1);
                out_free   <= free_total + COUNT_W'(1);
              end else begin
                out_free <= free_total;
              end
            end
          end
        end
        S_GET: begin
          free_head  <= link_rd_data;
          free_total <= free_total - COUNT_W'(1);
          out_valid  <= 1'b1;
          out_status <= ST_OK;
          out_addr   <= made_base + ADDR_W'(prod);
          out_free   <= free_total - COUNT_W'(1);
          state      <= S_IDLE;
        end
        S_FILL: begin
          fill_idx <= fill_idx + INDEX_W'(1);
          if (fill_done) begin
            free_head      <= '0;
            free_total     <= pool_blocks;
            capacity_total <= pool_blocks;
            made_base      <= pool_base;
            made_size      <= block_bytes;
            pool_made      <= 1'b1;
            out_valid      <= 1'b1;
            out_status     <= ST_OK;
            out_free       <= pool_blocks;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_free_within_capacity: assert property (@(posedge clk) disable iff (rst)
    free_total <= capacity_total)
    else $error("free count exceeds pool capacity");

  a_empty_before_create: assert property (@(posedge clk) disable iff (rst)
    !pool_made |-> (free_total == '0 && capacity_total == '0))
    else $error("free count nonzero before the pool is created");

  a_get_answers: assert property (@(posedge clk) disable iff (rst)
    (state == S_GET) |=> (out_valid && out_status == ST_OK && state == S_IDLE))
    else $error("get did not produce its result");

  a_get_pops_one: assert property (@(posedge clk) disable iff (rst)
    (state == S_GET) |=> (free_total == $past(free_total) - COUNT_W'(1)))
    else $error("get did not take exactly one block");

endmodule
